// ===== rtl/dbpe_pkg.sv =====
// Shared types and constants of the delta-binary-packed page encoder.
`timescale 1ns / 1ps

package dbpe_pkg;

	localparam int VALUE_W     = 64;
	localparam int COUNT_W     = 31;
	localparam int WIDTH_W     = 7;
	localparam int MINI_VALUES = 32;
	localparam int MINI_LOG    = 5;
	localparam int ACC_W       = 71;
	localparam int BITS_W      = 7;
	localparam int DI_W        = 6;

	// Source loaded into the varint shifter
	typedef enum logic [2:0] {
		VSRC_BS,
		VSRC_MB,
		VSRC_CNT,
		VSRC_FIRST,
		VSRC_MIN
	} vsrc_t;

	// Source of a result beat
	typedef enum logic [2:0] {
		RES_ZERO,
		RES_OVERRUN,
		RES_VARINT,
		RES_WIDTH,
		RES_PACK
	} res_src_t;

	typedef struct packed {
		logic     first_value;
		logic     next_value;
		logic     close_block;
		logic     sweep_wid;
		logic     vload;
		vsrc_t    vsrc;
		logic     vshift;
		logic     mb_clr;
		logic     mb_inc;
		logic     pk_setw;
		logic     pk_sub;
		logic     pk_app;
		logic     pk_out;
		logic     res_we;
		res_src_t res_src;
		logic     res_last;
	} dp_cmd_t;

	typedef struct packed {
		logic count_le1;
		logic left_is_one;
		logic fill_full;
		logic sweep_done;
		logic varint_last;
		logic wrd_zero;
		logic mb_last;
		logic mb_is_last_nz;
		logic any_nz;
		logic bits_ge8;
		logic mb_done;
	} dp_sts_t;

endpackage

// ===== rtl/dbpe_ctrl.sv =====
// Controller of the delta-binary-packed page encoder: handshakes and emission sequence.
`timescale 1ns / 1ps

module dbpe_ctrl import dbpe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  logic    mode,
	output logic    m_tvalid,
	input  logic    m_tready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SWMIN,
		S_SWWID,
		S_GEN,
		S_PWAIT,
		S_PSUB,
		S_PAPP
	} state_t;

	typedef enum logic [2:0] {
		E_NONE,
		E_HBS,
		E_HMB,
		E_HCNT,
		E_HFIRST,
		E_BMIN,
		E_BWID,
		E_BPACK
	} emit_t;

	state_t state_q, state_n;
	emit_t  emit_q, emit_n;
	logic   open_q, open_n;
	logic   end_q, end_n;
	logic   need_w_q, need_w_n;
	logic   mvalid_q, mvalid_n;
	logic   out_free;
	logic   accept;

	assign out_free = !mvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = mvalid_q;

	always_comb begin
		cmd      = '0;
		state_n  = state_q;
		emit_n   = emit_q;
		open_n   = open_q;
		end_n    = end_q;
		need_w_n = need_w_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (mode) begin
						if (emit_q == E_NONE) begin
							cmd.res_we  = 1'b1;
							cmd.res_src = RES_ZERO;
						end else begin
							state_n = S_GEN;
						end
					end else if (emit_q != E_NONE) begin
						cmd.res_we  = 1'b1;
						cmd.res_src = RES_OVERRUN;
					end else if (!open_q) begin
						cmd.first_value = 1'b1;
						cmd.vload       = 1'b1;
						cmd.vsrc        = VSRC_BS;
						emit_n          = E_HBS;
						if (sts.count_le1) begin
							end_n = 1'b1;
						end else begin
							open_n = 1'b1;
						end
					end else begin
						cmd.next_value = 1'b1;
						if (sts.left_is_one) begin
							cmd.close_block = 1'b1;
							open_n          = 1'b0;
							end_n           = 1'b1;
							state_n         = S_SWMIN;
						end else if (sts.fill_full) begin
							cmd.close_block = 1'b1;
							state_n         = S_SWMIN;
						end
					end
				end
			end
			S_SWMIN: begin
				if (sts.sweep_done) begin
					cmd.sweep_wid = 1'b1;
					state_n       = S_SWWID;
				end
			end
			S_SWWID: begin
				if (sts.sweep_done) begin
					cmd.vload = 1'b1;
					cmd.vsrc  = VSRC_MIN;
					emit_n    = E_BMIN;
					state_n   = S_IDLE;
				end
			end
			S_GEN: begin
				unique case (emit_q)
					E_HBS, E_HMB, E_HCNT, E_HFIRST, E_BMIN: begin
						cmd.res_we  = 1'b1;
						cmd.res_src = RES_VARINT;
						state_n     = S_IDLE;
						if (!sts.varint_last) begin
							cmd.vshift = 1'b1;
						end else begin
							unique case (emit_q)
								E_HBS: begin
									cmd.vload = 1'b1;
									cmd.vsrc  = VSRC_MB;
									emit_n    = E_HMB;
								end
								E_HMB: begin
									cmd.vload = 1'b1;
									cmd.vsrc  = VSRC_CNT;
									emit_n    = E_HCNT;
								end
								E_HCNT: begin
									cmd.vload = 1'b1;
									cmd.vsrc  = VSRC_FIRST;
									emit_n    = E_HFIRST;
								end
								E_HFIRST: begin
									cmd.res_last = end_q;
									end_n        = 1'b0;
									emit_n       = E_NONE;
								end
								default: begin
									cmd.mb_clr = 1'b1;
									emit_n     = E_BWID;
								end
							endcase
						end
					end
					E_BWID: begin
						cmd.res_we  = 1'b1;
						cmd.res_src = RES_WIDTH;
						state_n     = S_IDLE;
						if (!sts.mb_last) begin
							cmd.mb_inc = 1'b1;
						end else if (sts.any_nz) begin
							cmd.mb_clr = 1'b1;
							need_w_n   = 1'b1;
							emit_n     = E_BPACK;
						end else begin
							cmd.res_last = end_q;
							end_n        = 1'b0;
							emit_n       = E_NONE;
						end
					end
					E_BPACK: begin
						if (need_w_q) begin
							// skip miniblocks of width zero, they carry no bytes
							if (sts.wrd_zero) begin
								cmd.mb_inc = 1'b1;
								state_n    = S_PWAIT;
							end else begin
								cmd.pk_setw = 1'b1;
								need_w_n    = 1'b0;
							end
						end else if (sts.bits_ge8) begin
							cmd.res_we  = 1'b1;
							cmd.res_src = RES_PACK;
							cmd.pk_out  = 1'b1;
							state_n     = S_IDLE;
							if (sts.mb_done) begin
								if (sts.mb_is_last_nz) begin
									cmd.res_last = end_q;
									end_n        = 1'b0;
									emit_n       = E_NONE;
								end else begin
									cmd.mb_inc = 1'b1;
									need_w_n   = 1'b1;
								end
							end
						end else begin
							state_n = S_PSUB;
						end
					end
					default: begin
						state_n = S_IDLE;
					end
				endcase
			end
			S_PWAIT: begin
				state_n = S_GEN;
			end
			S_PSUB: begin
				cmd.pk_sub = 1'b1;
				state_n    = S_PAPP;
			end
			default: begin
				cmd.pk_app = 1'b1;
				state_n    = S_GEN;
			end
		endcase
		if (cmd.res_we) begin
			mvalid_n = 1'b1;
		end else if (m_tready) begin
			mvalid_n = 1'b0;
		end else begin
			mvalid_n = mvalid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			emit_q   <= E_NONE;
			open_q   <= 1'b0;
			end_q    <= 1'b0;
			need_w_q <= 1'b0;
			mvalid_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			emit_q   <= emit_n;
			open_q   <= open_n;
			end_q    <= end_n;
			need_w_q <= need_w_n;
			mvalid_q <= mvalid_n;
		end
	end

endmodule

// ===== rtl/dbpe_dp.sv =====
// Datapath of the delta-binary-packed page encoder: delta store, block sweeps, byte sources.
`timescale 1ns / 1ps

module dbpe_dp import dbpe_pkg::*; #(
	parameter int BLOCK_LEN = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	input  logic [VALUE_W-1:0] value,
	input  logic [COUNT_W-1:0] page_count,
	output logic [7:0]         out_byte,
	output logic               byte_valid,
	output logic               end_of_page,
	output logic [VALUE_W-1:0] page_min,
	output logic [VALUE_W-1:0] page_max,
	output logic               overrun
);

	localparam int MINI   = BLOCK_LEN / MINI_VALUES;
	localparam int IDX_W  = $clog2(BLOCK_LEN);
	localparam int FILL_W = $clog2(BLOCK_LEN + 1);
	localparam int MB_W   = $clog2(MINI);

	typedef enum logic [1:0] {
		SW_IDLE,
		SW_MIN,
		SW_WID
	} sweep_t;

	function automatic logic [VALUE_W-1:0] zz(input logic [VALUE_W-1:0] v);
		zz = {v[VALUE_W-2:0], 1'b0} ^ {VALUE_W{v[VALUE_W-1]}};
	endfunction

	function automatic logic [VALUE_W-1:0] smear(input logic [VALUE_W-1:0] v);
		logic [VALUE_W-1:0] s;
		s = v;
		s = s | (s >> 1);
		s = s | (s >> 2);
		s = s | (s >> 4);
		s = s | (s >> 8);
		s = s | (s >> 16);
		s = s | (s >> 32);
		smear = s;
	endfunction

	// bit length of a value whose thermometer mask is given
	function automatic logic [WIDTH_W-1:0] thermo_width(input logic [VALUE_W-1:0] t);
		logic [VALUE_W-1:0] oh;
		logic [WIDTH_W-1:0] w;
		oh = t & ~(t >> 1);
		w  = '0;
		for (int k = 0; k < VALUE_W; k++) begin
			if (oh[k]) begin
				w = w | WIDTH_W'(k + 1);
			end
		end
		thermo_width = w;
	endfunction

	logic [VALUE_W-1:0] dmem [BLOCK_LEN];
	logic [WIDTH_W-1:0] wmem [MINI];

	logic [VALUE_W-1:0] prev_q, rmin_q, rmax_q, bmin_q;
	logic [COUNT_W-1:0] left_q;
	logic [FILL_W-1:0]  fill_q, bfill_q;
	logic [VALUE_W-1:0] vq;
	logic [MB_W-1:0]    mb_q, last_nz_q;
	logic               any_nz_q;
	logic [ACC_W-1:0]   acc_q;
	logic [BITS_W-1:0]  bits_q;
	logic [WIDTH_W-1:0] wcur_q, wrd_q;
	logic [DI_W-1:0]    di_q;
	logic [VALUE_W-1:0] norm_q;
	logic [VALUE_W-1:0] mem_rd_s1;
	sweep_t             phase_q;
	logic [FILL_W-1:0]  sw_cnt_q;
	logic               v_s1, v_s2, fin_s3;
	logic [IDX_W-1:0]   idx_s1, idx_s2;
	logic [MB_W-1:0]    mb_s3;
	logic [VALUE_W-1:0] thermo_q;

	logic [COUNT_W-1:0] cnt_fix;
	logic [FILL_W-1:0]  limit;
	logic               issue, empty;
	logic [IDX_W-1:0]   pk_addr, raddr, nidx;
	logic [VALUE_W-1:0] norm;
	logic [WIDTH_W-1:0] wenc;
	logic [VALUE_W-1:0] vnext;
	logic               is_last;

	assign cnt_fix = sts.count_le1 ? COUNT_W'(1) : page_count;
	assign limit   = (phase_q == SW_MIN) ? bfill_q : FILL_W'(BLOCK_LEN);
	assign issue   = (phase_q != SW_IDLE) && (sw_cnt_q != limit);
	assign empty   = !v_s1 && !v_s2 && !fin_s3;
	assign pk_addr = IDX_W'({mb_q, di_q[MINI_LOG-1:0]});
	assign raddr   = (phase_q != SW_IDLE) ? sw_cnt_q[IDX_W-1:0] : pk_addr;
	assign nidx    = (phase_q != SW_IDLE) ? idx_s1 : pk_addr;
	// padding entries of a short block normalise to zero
	assign norm    = (FILL_W'(nidx) < bfill_q) ? (mem_rd_s1 - bmin_q) : '0;
	assign wenc    = thermo_width(thermo_q);
	assign is_last = vq[VALUE_W-1:7] == '0;

	always_comb begin
		unique case (cmd.vsrc)
			VSRC_BS:    vnext = VALUE_W'(BLOCK_LEN);
			VSRC_MB:    vnext = VALUE_W'(MINI);
			VSRC_CNT:   vnext = VALUE_W'(left_q) + VALUE_W'(1);
			VSRC_FIRST: vnext = zz(prev_q);
			default:    vnext = zz(bmin_q);
		endcase
	end

	always_comb begin
		sts.count_le1     = page_count[COUNT_W-1:1] == '0;
		sts.left_is_one   = left_q == COUNT_W'(1);
		sts.fill_full     = fill_q == FILL_W'(BLOCK_LEN - 1);
		sts.sweep_done    = (phase_q != SW_IDLE) && !issue && empty;
		sts.varint_last   = is_last;
		sts.wrd_zero      = wrd_q == '0;
		sts.mb_last       = mb_q == MB_W'(MINI - 1);
		sts.mb_is_last_nz = mb_q == last_nz_q;
		sts.any_nz        = any_nz_q;
		sts.bits_ge8      = bits_q >= BITS_W'(8);
		sts.mb_done       = (di_q == DI_W'(MINI_VALUES)) && (bits_q == BITS_W'(8));
	end

	// page state and block sweeps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			rmin_q    <= '0;
			rmax_q    <= '0;
			bmin_q    <= '0;
			left_q    <= '0;
			fill_q    <= '0;
			bfill_q   <= '0;
			phase_q   <= SW_IDLE;
			sw_cnt_q  <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			fin_s3    <= 1'b0;
			any_nz_q  <= 1'b0;
			last_nz_q <= '0;
			mb_q      <= '0;
		end else begin
			if (cmd.first_value) begin
				prev_q <= value;
				rmin_q <= value;
				rmax_q <= value;
				fill_q <= '0;
				left_q <= cnt_fix - COUNT_W'(1);
			end
			if (cmd.next_value) begin
				prev_q <= value;
				left_q <= left_q - COUNT_W'(1);
				if ($signed(value) < $signed(rmin_q)) begin
					rmin_q <= value;
				end
				if ($signed(rmax_q) < $signed(value)) begin
					rmax_q <= value;
				end
				fill_q <= cmd.close_block ? '0 : fill_q + FILL_W'(1);
			end
			if (cmd.close_block) begin
				bfill_q  <= fill_q + FILL_W'(1);
				phase_q  <= SW_MIN;
				sw_cnt_q <= '0;
			end else if (cmd.sweep_wid) begin
				phase_q  <= SW_WID;
				sw_cnt_q <= '0;
				any_nz_q <= 1'b0;
			end else if (sts.sweep_done) begin
				phase_q <= SW_IDLE;
			end else if (issue) begin
				sw_cnt_q <= sw_cnt_q + FILL_W'(1);
			end
			v_s1   <= issue && !cmd.close_block && !cmd.sweep_wid;
			v_s2   <= v_s1 && (phase_q == SW_WID);
			fin_s3 <= v_s2 && (idx_s2[MINI_LOG-1:0] == MINI_LOG'(MINI_VALUES - 1));
			if (v_s1 && (phase_q == SW_MIN)) begin
				if ((idx_s1 == '0) || ($signed(mem_rd_s1) < $signed(bmin_q))) begin
					bmin_q <= mem_rd_s1;
				end
			end
			if (fin_s3 && (wenc != '0)) begin
				any_nz_q  <= 1'b1;
				last_nz_q <= mb_s3;
			end
			if (cmd.mb_clr) begin
				mb_q <= '0;
			end else if (cmd.mb_inc) begin
				mb_q <= mb_q + MB_W'(1);
			end
		end
	end

	// sweep pipeline payload, varint shifter and packer
	always_ff @(posedge clk) begin
		idx_s1 <= sw_cnt_q[IDX_W-1:0];
		idx_s2 <= idx_s1;
		mb_s3  <= idx_s2[IDX_W-1:MINI_LOG];
		if ((v_s1 && (phase_q == SW_WID)) || cmd.pk_sub) begin
			norm_q <= norm;
		end
		if (v_s2) begin
			thermo_q <= ((idx_s2[MINI_LOG-1:0] == '0) ? '0 : thermo_q) | smear(norm_q);
		end
		if (cmd.vload) begin
			vq <= vnext;
		end else if (cmd.vshift) begin
			vq <= vq >> 7;
		end
		if (cmd.pk_setw) begin
			wcur_q <= wrd_q;
			di_q   <= '0;
			acc_q  <= '0;
			bits_q <= '0;
		end else if (cmd.pk_app) begin
			acc_q  <= acc_q | (ACC_W'(norm_q) << bits_q);
			bits_q <= bits_q + BITS_W'(wcur_q);
			di_q   <= di_q + DI_W'(1);
		end else if (cmd.pk_out) begin
			acc_q  <= acc_q >> 8;
			bits_q <= bits_q - BITS_W'(8);
		end
		if (cmd.res_we) begin
			end_of_page <= cmd.res_last;
			page_min    <= cmd.res_last ? rmin_q : '0;
			page_max    <= cmd.res_last ? rmax_q : '0;
			unique case (cmd.res_src)
				RES_ZERO: begin
					out_byte   <= '0;
					byte_valid <= 1'b0;
					overrun    <= 1'b0;
				end
				RES_OVERRUN: begin
					out_byte   <= '0;
					byte_valid <= 1'b0;
					overrun    <= 1'b1;
				end
				RES_VARINT: begin
					out_byte   <= {!is_last, vq[6:0]};
					byte_valid <= 1'b1;
					overrun    <= 1'b0;
				end
				RES_WIDTH: begin
					out_byte   <= 8'(wrd_q);
					byte_valid <= 1'b1;
					overrun    <= 1'b0;
				end
				default: begin
					out_byte   <= acc_q[7:0];
					byte_valid <= 1'b1;
					overrun    <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.next_value) begin
			dmem[fill_q[IDX_W-1:0]] <= value - prev_q;
		end
		mem_rd_s1 <= dmem[raddr];
	end

	always_ff @(posedge clk) begin
		if (fin_s3) begin
			wmem[mb_s3] <= wenc;
		end
		wrd_q <= wmem[mb_q];
	end

endmodule

// ===== rtl/delta_binary_packed_encoder.sv =====
// Top level of the delta-binary-packed page encoder.
`timescale 1ns / 1ps
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s       | in  | s_tvalid/s_tready  | s_tuser: mode; s_tdata: value, page_count
//  m       | out | m_tvalid/m_tready  | m_tuser: byte_valid, overrun; m_tlast:
//          |     |                    |   end_of_page; m_tdata: byte, min, max
//
//  A drain beat for a header, minimum or width byte goes through S_GEN; a packed byte
//  also reads the delta store, subtracts the block minimum and appends to the
//  accumulator for each delta it appends, loads the width at the start of a
//  miniblock and passes S_PWAIT for each empty miniblock skipped.
//  Closing a block sweeps the delta store twice, during which no beat is accepted.
//  arst_n clears the control state; the delta and width stores need no clearing.
//  A held result beat stalls further input only until m_tready takes it.
//
//  The first value of a page brings the page count and queues the header. Later
//  values become deltas in the store; a full block or the page end walks the store
//  for the block minimum, then for the bit width of each 32-delta miniblock. Bytes
//  are then produced one per drain beat. A value beat while bytes are pending is
//  dropped and answered with an overrun beat; a drain beat with nothing pending is
//  answered with an empty beat.

module delta_binary_packed_encoder import dbpe_pkg::*; #(
	parameter int BLOCK_LEN = 128
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // value [63:0], page_count [94:64], zero [95]
	input  logic [0:0]   s_tuser,   // mode [0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,   // out_byte [7:0], page_min [71:8], page_max [135:72]
	output logic [1:0]   m_tuser,   // byte_valid [0], overrun [1]
	output logic         m_tlast
);

	dp_cmd_t            cmd;
	dp_sts_t            sts;
	logic [7:0]         out_byte;
	logic               byte_valid;
	logic               overrun;
	logic [VALUE_W-1:0] page_min;
	logic [VALUE_W-1:0] page_max;

	dbpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.mode     (s_tuser[0]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	dbpe_dp #(
		.BLOCK_LEN (BLOCK_LEN)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.value       (s_tdata[63:0]),
		.page_count  (s_tdata[94:64]),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.end_of_page (m_tlast),
		.page_min    (page_min),
		.page_max    (page_max),
		.overrun     (overrun)
	);

	assign m_tdata = {page_max, page_min, out_byte};
	assign m_tuser = {overrun, byte_valid};

endmodule
